### rtl/mnep_pkg.sv
// shared types, constants and helper functions for the midi note event parser
// no dependencies; imported by mnep_step and midi_note_event_parser_unit

package mnep_pkg;

   // byte codes
   localparam logic [7:0] SysexStart    = 8'hF0;
   localparam logic [7:0] SysexEnd      = 8'b11110111;
   localparam logic [7:0] SysCommonLow  = 8'b11110001;
   localparam logic [7:0] RealTimeLow   = 8'hF8;
   localparam logic [7:0] SystemLow     = 8'b11110000;

   // channel message commands (upper nibble)
   localparam logic [3:0] CmdNoteOff    = 4'h8;
   localparam logic [3:0] CmdNoteOn     = 4'h9;
   localparam logic [3:0] CmdPitchBend  = 4'hE;
   localparam logic [3:0] CmdProgram    = 4'hC;
   localparam logic [3:0] CmdPressure   = 4'hD;

   typedef struct packed {
      logic [7:0] current_status;
      logic [6:0] first_data;
      logic [1:0] bytes_collected;
      logic [1:0] bytes_expected;
      logic       inside_sysex;
   } parser_state_type;

   typedef struct packed {
      logic       is_note_on;
      logic [6:0] note_number;
      logic [6:0] note_velocity;
   } note_event_type;

   typedef struct packed {
      logic           valid;
      note_event_type event_data;
   } step_result_type;

   // data bytes that follow a given status byte
   function automatic logic [1:0] data_count_for(input logic [7:0] status);
      logic [1:0] count;
      case (status[7:4]) inside
         CmdProgram, CmdPressure:       count = 2'd1;
         [CmdNoteOff:CmdPitchBend]:     count = 2'd2;
         default:                       count = 2'd0;
      endcase
      return count;
   endfunction

endpackage

### rtl/mnep_step.sv
// next-state and note event decode for one received byte
// depends on mnep_pkg

module mnep_step
   import mnep_pkg::*;
(
   input  logic [7:0]       rx_byte,
   input  logic [3:0]       listen_channel,
   input  parser_state_type state_cur,
   output parser_state_type state_next,
   output step_result_type  result
);

   logic [1:0] count_inc;
   logic [6:0] rx_payload;
   logic       handled;

   assign rx_payload = rx_byte[6:0];
   assign count_inc  = state_cur.bytes_collected + 2'd1;

   always_comb begin
      state_next = state_cur;
      result     = '0;
      handled    = 1'b0;

      if (rx_byte < RealTimeLow) begin
         // sysex: end marker and data are swallowed, other status bytes drop out
         if (state_cur.inside_sysex) begin
            if (rx_byte == SysexEnd) begin
               state_next.inside_sysex = 1'b0;
               handled                 = 1'b1;
            end else if (!rx_byte[7]) begin
               handled = 1'b1;
            end else begin
               state_next.inside_sysex = 1'b0;
            end
         end

         if (!handled) begin
            if (rx_byte[7]) begin
               state_next.bytes_collected = 2'd0;
               if (rx_byte == SysexStart) begin
                  state_next.inside_sysex   = 1'b1;
                  state_next.current_status = 8'd0;
                  state_next.bytes_expected = 2'd0;
               end else if (rx_byte >= SysCommonLow) begin
                  state_next.current_status = 8'd0;
                  state_next.bytes_expected = 2'd0;
               end else begin
                  state_next.current_status = rx_byte;
                  state_next.bytes_expected = data_count_for(rx_byte);
               end
            end else if (state_cur.current_status != 8'd0) begin
               if (state_cur.bytes_collected >= 2'd2) begin
                  state_next.bytes_collected = 2'd0;
               end else begin
                  if (state_cur.bytes_collected == 2'd0) begin
                     state_next.first_data = rx_payload;
                  end
                  if (count_inc < state_cur.bytes_expected) begin
                     state_next.bytes_collected = count_inc;
                  end else begin
                     state_next.bytes_collected = 2'd0;
                     if (state_cur.current_status < SystemLow &&
                         state_cur.current_status[3:0] == listen_channel) begin
                        result.event_data.note_number =
                           (state_cur.bytes_collected == 2'd0) ? rx_payload
                                                               : state_cur.first_data;
                        result.event_data.note_velocity = rx_payload;
                        if (state_cur.current_status[7:4] == CmdNoteOn) begin
                           result.valid                 = 1'b1;
                           result.event_data.is_note_on = (rx_payload != 7'd0);
                        end else if (state_cur.current_status[7:4] == CmdNoteOff) begin
                           result.valid                 = 1'b1;
                           result.event_data.is_note_on = 1'b0;
                        end
                     end
                  end
               end
            end
         end
      end
   end

endmodule

### rtl/midi_note_event_parser_unit.sv
// top level of the midi note event parser: parser state, result register and skid stage
// depends on mnep_pkg and mnep_step

// Takes one received MIDI byte per transaction on the req_ channel and reports
// Note On / Note Off messages for the channel held in the listen channel register
// as transactions on the rsp_ channel. Running status is supported, real-time
// bytes are dropped anywhere in the stream, SysEx content is skipped and system
// common bytes cancel running status. A Note On with velocity zero is reported
// with rsp_is_note_on low. Each byte is decoded in the cycle it is accepted and
// any event is registered in the result register, or in the skid stage when the
// result register is stalled, so the block takes one byte per clock cycle while
// req_ready is high. A one-entry skid stage behind the result register lets the
// block keep taking bytes while a result waits; req_ready drops only when both
// the result register and the skid stage hold events. The listen channel is
// written through the csr_ channel, which is always ready, and should only be
// changed while no transaction is in flight.

module midi_note_event_parser_unit
   import mnep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   // received byte transactions
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,

   // note event transactions
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_note_on,
   output logic [6:0] rsp_note_number,
   output logic [6:0] rsp_note_velocity,

   // listen channel register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_listen_channel
);

   // configuration
   logic [3:0]       listen_channel_ff;

   // parser state
   parser_state_type state_ff;
   parser_state_type state_in;
   step_result_type  step_result;

   // result register and skid stage
   logic             out_valid_ff;
   logic             out_valid_in;
   note_event_type   out_data_ff;
   note_event_type   out_data_in;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   note_event_type   skid_data_ff;
   note_event_type   skid_data_in;

   logic             req_accept;
   logic             new_event;
   logic             out_free;

   assign csr_ready  = 1'b1;
   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign new_event  = req_accept && step_result.valid;
   // result register can load when empty or being drained this cycle
   assign out_free   = !out_valid_ff || rsp_ready;

   mnep_step u_step (
      .rx_byte        (req_rx_byte),
      .listen_channel (listen_channel_ff),
      .state_cur      (state_ff),
      .state_next     (state_in),
      .result         (step_result)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;

      if (out_free) begin
         if (skid_valid_ff) begin
            // waiting event moves up; no byte is taken while the skid is full
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_event;
            out_data_in  = step_result.event_data;
         end
      end else if (new_event) begin
         // result register stalled: park the fresh event in the skid stage
         skid_valid_in = 1'b1;
         skid_data_in  = step_result.event_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_channel_ff <= 4'd0;
         state_ff          <= '0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            listen_channel_ff <= csr_listen_channel;
         end
         if (req_accept) begin
            state_ff <= state_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_is_note_on    = out_data_ff.is_note_on;
   assign rsp_note_number   = out_data_ff.note_number;
   assign rsp_note_velocity = out_data_ff.note_velocity;

endmodule

### tb/sv/midi_note_event_parser_unit_tb.sv
// self-checking testbench for midi_note_event_parser_unit: directed table, then random streams
// depends on mnep_pkg and the midi_note_event_parser_unit rtl; a note predictor checks events

`timescale 1ns / 1ps

module midi_note_event_parser_unit_tb
   import mnep_pkg::*;
();

   // top of the real-time range, used when picking a random real-time byte
   localparam logic [7:0] RealTimeHigh = 8'hFF;
   // settle time after the last expected event, covers result register and skid stage
   localparam int SettleCycles = 4;
   localparam int PhaseCount = 5;
   localparam int BytesPerPhase = 100;
   localparam int ReportLimit = 10;

   // one row of the directed table; typed rows carry their own expected event
   typedef struct packed {
      logic [7:0]     rx;
      bit             typed;
      bit             fires;
      note_event_type evt;
   } directed_row_type;

   localparam note_event_type NoEvent = '{1'b0, 7'h00, 7'h00};

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_is_note_on;
   logic [6:0] rsp_note_number;
   logic [6:0] rsp_note_velocity;
   logic       csr_valid;
   logic       csr_ready;
   logic [3:0] csr_listen_channel;

   // predictor state: running status, first data byte, data byte counts, sysex flag
   logic [7:0] run_status;
   logic [6:0] held_key;
   logic [1:0] data_seen;
   logic [1:0] data_needed;
   logic       sysex_open;
   logic [3:0] listen_ch;

   note_event_type note_queue[$];
   logic [7:0]     byte_queue[$];
   note_event_type want;

   bit idling_on;
   int mismatch_count;
   int events_checked;
   int bytes_sent;

   // directed stimulus: running status, velocity-zero note on, other channel,
   // program change, sysex left by a status byte, real-time inside sysex,
   // stray data after sysex and after a system common byte
   directed_row_type directed_rows [0:24] = '{
      '{8'h45,                1'b1, 1'b0, NoEvent},
      '{{CmdNoteOn, 4'd0},    1'b1, 1'b0, NoEvent},
      '{8'h00,                1'b1, 1'b0, NoEvent},
      '{8'h7F,                1'b1, 1'b1, '{1'b1, 7'h00, 7'h7F}},
      '{8'h7F,                1'b1, 1'b0, NoEvent},
      '{8'h00,                1'b1, 1'b1, '{1'b0, 7'h7F, 7'h00}},
      '{{CmdNoteOff, 4'd0},   1'b0, 1'b0, NoEvent},
      '{8'h3C,                1'b0, 1'b0, NoEvent},
      '{8'h7F,                1'b1, 1'b1, '{1'b0, 7'h3C, 7'h7F}},
      '{{CmdNoteOn, 4'd1},    1'b0, 1'b0, NoEvent},
      '{8'h10,                1'b0, 1'b0, NoEvent},
      '{8'h20,                1'b1, 1'b0, NoEvent},
      '{{CmdProgram, 4'd0},   1'b0, 1'b0, NoEvent},
      '{8'h05,                1'b1, 1'b0, NoEvent},
      '{SysexStart,           1'b0, 1'b0, NoEvent},
      '{8'h12,                1'b0, 1'b0, NoEvent},
      '{{CmdNoteOn, 4'd0},    1'b0, 1'b0, NoEvent},
      '{8'h01,                1'b0, 1'b0, NoEvent},
      '{8'h02,                1'b0, 1'b0, NoEvent},
      '{SysexStart,           1'b0, 1'b0, NoEvent},
      '{RealTimeHigh,         1'b0, 1'b0, NoEvent},
      '{SysexEnd,             1'b0, 1'b0, NoEvent},
      '{8'h66,                1'b1, 1'b0, NoEvent},
      '{SysCommonLow,         1'b0, 1'b0, NoEvent},
      '{8'h11,                1'b1, 1'b0, NoEvent}
   };

   midi_note_event_parser_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_note_on     (rsp_is_note_on),
      .rsp_note_number    (rsp_note_number),
      .rsp_note_velocity  (rsp_note_velocity),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_listen_channel (csr_listen_channel)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // works out the note event, if any, that one accepted byte causes
   task automatic predict_note(input logic [7:0] rx, output bit fires,
                               output note_event_type evt);
      logic [3:0] cmd;
      fires = 1'b0;
      evt = NoEvent;
      // real-time bytes pass through every state untouched
      if (rx >= RealTimeLow) return;
      if (sysex_open) begin
         if (rx == SysexEnd) begin
            sysex_open = 1'b0;
            return;
         end
         if (!rx[7]) return;
         // any other status byte ends sysex and is then decoded as usual
         sysex_open = 1'b0;
      end
      if (rx[7]) begin
         if (rx == SysexStart) begin
            sysex_open = 1'b1;
            run_status = '0;
            data_seen = '0;
            data_needed = '0;
         end else if (rx >= SysCommonLow) begin
            // system common cancels running status
            run_status = '0;
            data_seen = '0;
            data_needed = '0;
         end else begin
            run_status = rx;
            data_seen = '0;
            data_needed = (rx[7:4] == CmdProgram || rx[7:4] == CmdPressure) ? 2'd1 : 2'd2;
         end
         return;
      end
      // data byte from here on; stray data with no running status is dropped
      if (run_status == '0) return;
      if (data_seen >= 2'd2) begin
         data_seen = '0;
         return;
      end
      if (data_seen == 2'd0) held_key = rx[6:0];
      data_seen = data_seen + 2'd1;
      if (data_seen < data_needed) return;
      data_seen = '0;
      if (run_status >= SystemLow || run_status[3:0] != listen_ch) return;
      cmd = run_status[7:4];
      if (cmd == CmdNoteOn || cmd == CmdNoteOff) begin
         fires = 1'b1;
         evt.is_note_on = (cmd == CmdNoteOn) && (rx[6:0] != 7'd0);
         evt.note_number = held_key;
         evt.note_velocity = rx[6:0];
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < ReportLimit) $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   // one byte transaction on the req_ channel, with an optional idle burst ahead of it
   task automatic send_byte(input logic [7:0] rx);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // byte goes into the stream, now and then after a real-time byte
   task automatic push_stream(input logic [7:0] rx);
      if ($urandom_range(0, 15) == 0) begin
         byte_queue.push_back(8'($urandom_range(RealTimeLow, RealTimeHigh)));
      end
      byte_queue.push_back(rx);
   endtask

   // one random midi message, mostly well-formed notes for the listen channel
   task automatic queue_random_message();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
         // note on or off for the listen channel, with or without running status
         if ($urandom_range(0, 2) != 0)
            push_stream({($urandom_range(0, 1) != 0) ? CmdNoteOn : CmdNoteOff, listen_ch});
         push_stream(8'($urandom_range(0, 127)));
         push_stream(($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 127)));
      end else if (kind < 65) begin
         // any channel message on any channel
         push_stream({4'($urandom_range(CmdNoteOff, CmdPitchBend)), 4'($urandom_range(0, 15))});
         n = $urandom_range(1, 2);
         repeat (n) push_stream(8'($urandom_range(0, 127)));
      end else if (kind < 75) begin
         // sysex block, usually closed by end of exclusive, sometimes by a status byte
         push_stream(SysexStart);
         n = $urandom_range(0, 5);
         repeat (n) push_stream(8'($urandom_range(0, 127)));
         if ($urandom_range(0, 3) != 0) push_stream(SysexEnd);
         else push_stream(8'($urandom_range(8'h80, SystemLow - 8'd1)));
      end else if (kind < 85) begin
         // system common with a little trailing data
         push_stream(8'($urandom_range(SysCommonLow, SysexEnd)));
         n = $urandom_range(0, 2);
         repeat (n) push_stream(8'($urandom_range(0, 127)));
      end else begin
         push_stream(8'($urandom_range(0, 255)));
      end
   endtask

   // lets every expected event drain, then waits out the settle time for the skid stage
   task automatic drain_events();
      req_valid <= 1'b0;
      while (note_queue.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_listen_channel(input logic [3:0] ch);
      csr_valid <= 1'b1;
      csr_listen_channel <= ch;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      listen_ch = ch;
   endtask

   // receiver side: ready with random stall bursts while idling is on
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // result checker: each event transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (note_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected event on=%0b key=%0d vel=%0d",
                                      rsp_is_note_on, rsp_note_number, rsp_note_velocity));
         end else begin
            want = note_queue.pop_front();
            if (rsp_is_note_on !== want.is_note_on || rsp_note_number !== want.note_number
                || rsp_note_velocity !== want.note_velocity)
               report_mismatch($sformatf("exp on=%0b key=%0d vel=%0d, got on=%0b key=%0d vel=%0d",
                                         want.is_note_on, want.note_number, want.note_velocity,
                                         rsp_is_note_on, rsp_note_number, rsp_note_velocity));
            events_checked++;
         end
      end
   end

   initial begin : stimulus
      bit             fires;
      note_event_type evt;
      logic [3:0]     ch;

      // every input known from time zero
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      csr_valid = 1'b0;
      csr_listen_channel = '0;
      idling_on = 1'b1;
      mismatch_count = 0;
      events_checked = 0;
      bytes_sent = 0;
      run_status = '0;
      held_key = '0;
      data_seen = '0;
      data_needed = '0;
      sysex_open = 1'b0;
      listen_ch = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table on the reset listen channel
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].rx);
         predict_note(directed_rows[i].rx, fires, evt);
         if (directed_rows[i].typed) begin
            fires = directed_rows[i].fires;
            evt = directed_rows[i].evt;
         end
         if (fires) note_queue.push_back(evt);
      end
      drain_events();

      // random phases: extremes of the listen channel first, then random ones,
      // the last phase with no idling on either side
      for (int p = 0; p < PhaseCount; p++) begin
         if (p == 0) ch = 4'd15;
         else if (p == 1) ch = 4'd0;
         else ch = 4'($urandom_range(0, 15));
         write_listen_channel(ch);
         idling_on = (p != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < BytesPerPhase; ) begin
            queue_random_message();
            while (byte_queue.size() != 0) begin
               evt = NoEvent;
               send_byte(byte_queue[0]);
               predict_note(byte_queue.pop_front(), fires, evt);
               if (fires) note_queue.push_back(evt);
               n++;
            end
         end
         drain_events();
      end

      repeat (10) @(posedge clock);
      while (note_queue.size() != 0) begin
         want = note_queue.pop_front();
         report_mismatch($sformatf("missing event on=%0b key=%0d vel=%0d",
                                   want.is_note_on, want.note_number, want.note_velocity));
      end

      $display("run covered %0d bytes and %0d note events over %0d listen channel settings",
               bytes_sent, events_checked, PhaseCount + 1);
      $display("mismatches counted: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
